### rtl/core/pfrf_pkg.sv
package pfrf_pkg;

  // fixed widths of the command fields
  localparam int COL_W    = 8;
  localparam int PAGE_W   = 5;
  localparam int ROW_BITS = 3;

  localparam logic [7:0] FULL_BYTE  = 8'hff;
  localparam logic [7:0] EMPTY_BYTE = 8'h00;

  // command codes
  localparam logic [1:0] ACT_FILL  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_WIDTH  = 2'd1;
  localparam logic [1:0] STAT_HEIGHT = 2'd2;

  // store access kinds
  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_PEEK  = 2'd2
  } op_t;

  // one store access per cycle
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  col;
    logic [7:0]        mask;
  } store_req_t;

  // bounds of one sweep over the store
  typedef struct packed {
    op_t                 op;
    logic [COL_W-1:0]    col_first;
    logic [COL_W-1:0]    col_last;
    logic [PAGE_W-1:0]   page_first;
    logic [PAGE_W-1:0]   page_last;
    logic [ROW_BITS-1:0] top_off;
    logic [ROW_BITS-1:0] bot_off;
  } walk_cfg_t;

endpackage

### rtl/core/pfrf_if.sv
interface pfrf_cmd_if ();
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] x_first;
  logic [7:0] y_first;
  logic [7:0] x_last;
  logic [7:0] y_last;
  logic [2:0] read_page;
  logic [6:0] read_column;

  modport source (
    output valid, action, x_first, y_first, x_last, y_last, read_page, read_column,
    input  ready
  );
  modport sink (
    input  valid, action, x_first, y_first, x_last, y_last, read_page, read_column,
    output ready
  );
endinterface

interface pfrf_rsp_if ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] read_data;

  modport source (output valid, status, read_data, input ready);
  modport sink (input valid, status, read_data, output ready);
endinterface

### rtl/core/pfrf_walk.sv
module pfrf_walk #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_PAGES   = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  pfrf_pkg::walk_cfg_t  cfg,
  output logic                 busy,
  output pfrf_pkg::store_req_t req
);
  import pfrf_pkg::*;

  localparam int CW = $clog2(SCREEN_COLUMNS);
  localparam int PW = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;

  logic [CW-1:0]       col;
  logic [PW-1:0]       page;
  logic [CW-1:0]       col_last;
  logic [PW-1:0]       page_first;
  logic [PW-1:0]       page_last;
  logic [ROW_BITS-1:0] top_off;
  logic [ROW_BITS-1:0] bot_off;
  op_t                 op;

  logic                at_top;
  logic                at_bottom;
  logic [ROW_BITS-1:0] lo;
  logic [ROW_BITS-1:0] hi;

  always_comb begin
    at_top    = (page == page_first);
    at_bottom = (page == page_last);
    lo        = at_top ? top_off : '0;
    hi        = at_bottom ? bot_off : '0;
    req.valid = busy;
    req.op    = op;
    req.page  = PAGE_W'(page);
    req.col   = COL_W'(col);
    req.mask  = (FULL_BYTE << lo) & (FULL_BYTE >> hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && at_bottom && (col == col_last)) begin
      busy <= 1'b0;
    end
  end

  // pages inner, columns outer
  always_ff @(posedge clk) begin
    if (start) begin
      col        <= cfg.col_first[CW-1:0];
      page       <= cfg.page_first[PW-1:0];
      col_last   <= cfg.col_last[CW-1:0];
      page_first <= cfg.page_first[PW-1:0];
      page_last  <= cfg.page_last[PW-1:0];
      top_off    <= cfg.top_off;
      bot_off    <= cfg.bot_off;
      op         <= cfg.op;
    end else if (busy) begin
      if (at_bottom) begin
        page <= page_first;
        col  <= col + 1'b1;
      end else begin
        page <= page + 1'b1;
      end
    end
  end

endmodule

### rtl/core/pfrf_store.sv
module pfrf_store #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_PAGES   = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pfrf_pkg::store_req_t req,
  output logic [7:0]           rdata
);
  import pfrf_pkg::*;

  localparam int CW    = $clog2(SCREEN_COLUMNS);
  localparam int PW    = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
  localparam int AW    = PW + CW;
  localparam int DEPTH = 1 << AW;

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_mask;
  logic          wr_clear;
  logic          wr_valid;

  assign addr = {req.page[PW-1:0], req.col[CW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else begin
      wr_valid <= req.valid && (req.op != OP_PEEK);
    end
  end

  // the read registers the byte, address and mask; the merge and write back use those registers
  always_ff @(posedge clk) begin
    if (req.valid) begin
      rdata <= mem[addr];
    end
    wr_addr  <= addr;
    wr_mask  <= req.mask;
    wr_clear <= (req.op == OP_CLEAR);
    if (wr_valid) begin
      mem[wr_addr] <= wr_clear ? EMPTY_BYTE : (rdata | wr_mask);
    end
  end

endmodule

### rtl/core/page_framebuffer_rect_fill_core.sv
// fill: the walker sweeps the columns x pages covered, then the result is registered;
//   one store byte per cycle, set by the single store port pair; ready again with the result
// clear: sweeps the whole screen; read: one byte through the store; rejects: result only
// throughput: one command at a time; a result not taken holds off the next command
// reset: synchronous, active high; afterwards a clearing pass over the whole screen
//   runs before the first command is taken
module page_framebuffer_rect_fill_core #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_PAGES   = 8
) (
  input logic        clk,
  input logic        rst,
  pfrf_cmd_if.sink   cmd,
  pfrf_rsp_if.source rsp
);
  import pfrf_pkg::*;

  localparam int SCREEN_ROWS = 8 * SCREEN_PAGES;

  // sequencer states
  typedef enum logic [6:0] {
    ST_INIT     = 7'b0000001,  // kick off the clearing pass after reset
    ST_WIPE     = 7'b0000010,  // clearing pass in progress
    ST_IDLE     = 7'b0000100,  // waiting for a command transfer
    ST_SWEEP    = 7'b0001000,  // fill or clear sweep in progress
    ST_PEEK     = 7'b0010000,  // single byte read issued
    ST_PEEKWAIT = 7'b0100000,  // read data returns
    ST_FINISH   = 7'b1000000   // hand the result to the output register
  } state_t;

  state_t     state;
  state_t     state_next;
  state_t     accept_state;

  logic       accept;
  logic       slot_free;
  logic       width_bad;
  logic       height_bad;
  logic       rcol_bad;
  logic       rpage_bad;
  logic [1:0] dec_status;

  walk_cfg_t  fill_cfg;
  walk_cfg_t  clear_cfg;
  walk_cfg_t  walk_cfg;
  logic       walk_start;
  logic       walk_busy;
  store_req_t walk_req;
  store_req_t store_req;
  logic [7:0] store_rdata;

  // pending result and read address
  logic [1:0]        status_q;
  logic [7:0]        data_q;
  logic [PAGE_W-1:0] peek_page;
  logic [COL_W-1:0]  peek_col;

  // output register
  logic       rsp_valid;
  logic [1:0] rsp_status;
  logic [7:0] rsp_data;

  assign cmd.ready     = (state == ST_IDLE);
  assign accept        = cmd.valid && cmd.ready;
  assign slot_free     = !rsp_valid || rsp.ready;
  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.read_data = rsp_data;

  // bounds checks, widened so a full 256 wide or tall screen compares right
  always_comb begin
    width_bad  = (9'(cmd.x_last) >= 9'(SCREEN_COLUMNS)) || (cmd.x_last < cmd.x_first);
    height_bad = (9'(cmd.y_last) >= 9'(SCREEN_ROWS)) || (cmd.y_last < cmd.y_first);
    rcol_bad   = 9'(cmd.read_column) >= 9'(SCREEN_COLUMNS);
    rpage_bad  = 6'(cmd.read_page) >= 6'(SCREEN_PAGES);
  end

  // command decode: status to report and where the sequencer goes next
  always_comb begin
    dec_status   = STAT_OK;
    accept_state = ST_FINISH;
    case (cmd.action)
      ACT_FILL: begin
        if (width_bad) begin
          dec_status = STAT_WIDTH;
        end else if (height_bad) begin
          dec_status = STAT_HEIGHT;
        end else begin
          accept_state = ST_SWEEP;
        end
      end
      ACT_CLEAR: begin
        accept_state = ST_SWEEP;
      end
      ACT_READ: begin
        if (rcol_bad) begin
          dec_status = STAT_WIDTH;
        end else if (rpage_bad) begin
          dec_status = STAT_HEIGHT;
        end else begin
          accept_state = ST_PEEK;
        end
      end
      default: begin
        // unused code: nothing happens, status ok
        accept_state = ST_FINISH;
      end
    endcase
  end

  // sweep bounds: fill covers the rectangle, clear covers the whole screen
  always_comb begin
    fill_cfg.op         = OP_FILL;
    fill_cfg.col_first  = cmd.x_first;
    fill_cfg.col_last   = cmd.x_last;
    fill_cfg.page_first = cmd.y_first[7:ROW_BITS];
    fill_cfg.page_last  = cmd.y_last[7:ROW_BITS];
    fill_cfg.top_off    = cmd.y_first[ROW_BITS-1:0];
    fill_cfg.bot_off    = ~cmd.y_last[ROW_BITS-1:0];

    clear_cfg.op         = OP_CLEAR;
    clear_cfg.col_first  = '0;
    clear_cfg.col_last   = COL_W'(SCREEN_COLUMNS - 1);
    clear_cfg.page_first = '0;
    clear_cfg.page_last  = PAGE_W'(SCREEN_PAGES - 1);
    clear_cfg.top_off    = '0;
    clear_cfg.bot_off    = '0;

    walk_start = (state == ST_INIT) || (accept && (accept_state == ST_SWEEP));
    walk_cfg   = ((state == ST_INIT) || (cmd.action == ACT_CLEAR)) ? clear_cfg : fill_cfg;
  end

  // address walker drives the store, except for the single byte read
  always_comb begin
    if (state == ST_PEEK) begin
      store_req.valid = 1'b1;
      store_req.op    = OP_PEEK;
      store_req.page  = peek_page;
      store_req.col   = peek_col;
      store_req.mask  = FULL_BYTE;
    end else begin
      store_req = walk_req;
    end
  end

  // sequencer; the sweep ends once the walker has dropped busy, on the edge on which
  // the last write back lands
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:     state_next = ST_WIPE;
      ST_WIPE:     if (!walk_busy) state_next = ST_IDLE;
      ST_IDLE:     if (cmd.valid) state_next = accept_state;
      ST_SWEEP:    if (!walk_busy) state_next = ST_FINISH;
      ST_PEEK:     state_next = ST_PEEKWAIT;
      ST_PEEKWAIT: state_next = ST_FINISH;
      ST_FINISH:   if (slot_free) state_next = ST_IDLE;
      default:     state_next = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_FINISH) && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q  <= dec_status;
      data_q    <= EMPTY_BYTE;
      peek_page <= PAGE_W'(cmd.read_page);
      peek_col  <= COL_W'(cmd.read_column);
    end
    if (state == ST_PEEKWAIT) begin
      data_q <= store_rdata;
    end
    // output register loads when it is empty or while the held result is taken
    if ((state == ST_FINISH) && slot_free) begin
      rsp_status <= status_q;
      rsp_data   <= data_q;
    end
  end

  pfrf_walk #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_PAGES   (SCREEN_PAGES)
  ) u_walk (
    .clk   (clk),
    .rst   (rst),
    .start (walk_start),
    .cfg   (walk_cfg),
    .busy  (walk_busy),
    .req   (walk_req)
  );

  pfrf_store #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_PAGES   (SCREEN_PAGES)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (store_req),
    .rdata (store_rdata)
  );

endmodule
